>>> sv/ils_pkg.sv
package ils_pkg;

  // Default sizes handed to the top level.
  localparam int DepthDef      = 256;
  localparam int ValueWidthDef = 32;

  // Fixed field widths of the request and result ports.
  localparam int OpcodeW   = 3;
  localparam int PositionW = 8;
  localparam int ElemW     = 32;
  localparam int StatusW   = 2;
  localparam int FoundIdxW = 8;
  localparam int CountOutW = 9;

  typedef enum logic [OpcodeW-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_READ   = 3'd3,
    OP_WRITE  = 3'd4,
    OP_SEARCH = 3'd5,
    OP_CLEAR  = 3'd6
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_NULL      = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Command broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROTATE
  } cell_op_e;

endpackage

>>> sv/indexed_list_store.sv
// Ordered list of nonzero words held in a chain of DEPTH cells. A request is
// taken when start is high and busy is low, and its result appears on the
// result ports for exactly one cycle with done_o high; the receiver cannot
// stall, so it must take every result in that cycle. Append, insert, write,
// clear, the unused opcode and every rejected request finish without leaving
// idle: the next request may follow in the next cycle. Read and search
// rotate the occupied cells once past the head cell, one entry per cycle,
// and remove does the same and then shifts the later entries down in a
// further state. The cells have no reset; nothing beyond the count is
// ever read.
module indexed_list_store #(
  parameter int DEPTH       = ils_pkg::DepthDef,
  parameter int VALUE_WIDTH = ils_pkg::ValueWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [ils_pkg::OpcodeW-1:0]      opcode_i,
  input  logic [ils_pkg::PositionW-1:0]    position_i,
  input  logic [ils_pkg::ElemW-1:0]        element_value_i,
  output logic                             done_o,
  output logic [ils_pkg::StatusW-1:0]      status_o,
  output logic [ils_pkg::ElemW-1:0]        result_value_o,
  output logic [ils_pkg::FoundIdxW-1:0]    found_index_o,
  output logic                             found_o,
  output logic [ils_pkg::CountOutW-1:0]    entry_count_o,
  output logic                             is_empty_o
);

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int CmpW = (CntW > ils_pkg::PositionW) ? CntW : ils_pkg::PositionW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_e;

  state_e               state_q;
  logic                 done_q;
  ils_pkg::status_e     status_q;
  logic [VALUE_WIDTH-1:0] rval_q;
  logic [CntW-1:0]      fidx_q;
  logic                 found_q;
  logic [CntW-1:0]      count_q;
  logic [CntW-1:0]      scan_q;
  logic [CmpW-1:0]      pos_q;
  logic [VALUE_WIDTH-1:0] val_q;
  ils_pkg::opcode_e     op_q;

  logic                   accept;
  logic [VALUE_WIDTH-1:0] val_in;
  logic [CmpW-1:0]        pos_ext;
  logic [CmpW-1:0]        cnt_ext;
  logic                   is_null;
  logic                   is_full;
  ils_pkg::opcode_e       op_in;

  ils_pkg::status_e       acc_status;
  logic                   acc_scan;
  logic [CntW-1:0]        acc_count;
  ils_pkg::cell_op_e      acc_cell_op;
  logic [CmpW-1:0]        acc_cell_pos;

  ils_pkg::cell_op_e      cell_op;
  logic [CmpW-1:0]        cell_pos;
  logic [VALUE_WIDTH-1:0] cell_q [DEPTH];
  logic [VALUE_WIDTH-1:0] head;

  logic                   scan_last;
  logic                   scan_pos_hit;
  logic                   search_hit;

  assign accept  = start && !busy;
  assign busy    = (state_q != S_IDLE);
  assign val_in  = VALUE_WIDTH'(element_value_i);
  assign pos_ext = CmpW'(position_i);
  assign cnt_ext = CmpW'(count_q);
  assign is_null = (val_in == '0);
  assign is_full = (count_q == CntW'(DEPTH));
  assign op_in   = ils_pkg::opcode_e'(opcode_i);
  assign head    = cell_q[0];

  // Decode a new request: its checks, its cell command and whether it scans.
  always_comb begin
    acc_status   = ils_pkg::ST_OK;
    acc_scan     = 1'b0;
    acc_count    = count_q;
    acc_cell_op  = ils_pkg::CELL_HOLD;
    acc_cell_pos = pos_ext;
    unique case (op_in)
      ils_pkg::OP_APPEND: begin
        if (is_null) begin
          acc_status = ils_pkg::ST_NULL;
        end else if (is_full) begin
          acc_status = ils_pkg::ST_FULL;
        end else begin
          acc_cell_op  = ils_pkg::CELL_WRITE;
          acc_cell_pos = cnt_ext;
          acc_count    = count_q + CntW'(1);
        end
      end
      ils_pkg::OP_INSERT: begin
        if (is_null) begin
          acc_status = ils_pkg::ST_NULL;
        end else if (pos_ext > cnt_ext) begin
          acc_status = ils_pkg::ST_BAD_INDEX;
        end else if (is_full) begin
          acc_status = ils_pkg::ST_FULL;
        end else begin
          acc_cell_op = ils_pkg::CELL_INSERT;
          acc_count   = count_q + CntW'(1);
        end
      end
      ils_pkg::OP_REMOVE, ils_pkg::OP_READ: begin
        if (pos_ext >= cnt_ext) begin
          acc_status = ils_pkg::ST_BAD_INDEX;
        end else begin
          acc_scan = 1'b1;
        end
      end
      ils_pkg::OP_WRITE: begin
        if (is_null) begin
          acc_status = ils_pkg::ST_NULL;
        end else if (pos_ext >= cnt_ext) begin
          acc_status = ils_pkg::ST_BAD_INDEX;
        end else begin
          acc_cell_op = ils_pkg::CELL_WRITE;
        end
      end
      ils_pkg::OP_SEARCH: begin
        if (is_null) begin
          acc_status = ils_pkg::ST_NULL;
        end else if (count_q != '0) begin
          acc_scan = 1'b1;
        end
      end
      ils_pkg::OP_CLEAR: begin
        acc_count = '0;
      end
      default: begin
        acc_status = ils_pkg::ST_OK;
      end
    endcase
  end

  // Command for the chain in the current cycle.
  always_comb begin
    cell_op  = ils_pkg::CELL_HOLD;
    cell_pos = pos_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cell_op  = acc_cell_op;
          cell_pos = acc_cell_pos;
        end
      end
      S_SCAN:  cell_op = ils_pkg::CELL_ROTATE;
      S_SHIFT: cell_op = ils_pkg::CELL_REMOVE;
      default: cell_op = ils_pkg::CELL_HOLD;
    endcase
  end

  // The row of cells; each sees its two neighbors and the head cell.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left;
    logic [VALUE_WIDTH-1:0] right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_inner_left
      assign left = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = cell_q[i];
    end else begin : g_inner_right
      assign right = cell_q[i+1];
    end
    ils_cell #(
      .INDEX       (i),
      .CMP_W       (CmpW),
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op),
      .pos_i   (cell_pos),
      .cnt_i   (cnt_ext),
      .value_i (val_in),
      .left_i  (left),
      .right_i (right),
      .head_i  (head),
      .data_o  (cell_q[i])
    );
  end

  // The head cell holds entry scan_q while the chain rotates.
  assign scan_last    = ((scan_q + CntW'(1)) == count_q);
  assign scan_pos_hit = (CmpW'(scan_q) == pos_q);
  assign search_hit   = (head == val_q) && !found_q;

  // Sequencer and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      done_q   <= 1'b0;
      count_q  <= '0;
      scan_q   <= '0;
      status_q <= ils_pkg::ST_OK;
      found_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            status_q <= acc_status;
            count_q  <= acc_count;
            rval_q   <= '0;
            fidx_q   <= '0;
            found_q  <= 1'b0;
            scan_q   <= '0;
            pos_q    <= pos_ext;
            val_q    <= val_in;
            op_q     <= op_in;
            if (acc_scan) begin
              state_q <= S_SCAN;
            end else begin
              done_q <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (op_q != ils_pkg::OP_SEARCH && scan_pos_hit) rval_q <= head;
          if (op_q == ils_pkg::OP_SEARCH && search_hit) begin
            found_q <= 1'b1;
            fidx_q  <= scan_q;
          end
          scan_q <= scan_q + CntW'(1);
          if (scan_last) begin
            if (op_q == ils_pkg::OP_REMOVE) begin
              state_q <= S_SHIFT;
            end else begin
              state_q <= S_IDLE;
              done_q  <= 1'b1;
            end
          end
        end
        S_SHIFT: begin
          count_q <= count_q - CntW'(1);
          state_q <= S_IDLE;
          done_q  <= 1'b1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o         = done_q;
  assign status_o       = ils_pkg::StatusW'(status_q);
  assign result_value_o = ils_pkg::ElemW'(rval_q);
  assign found_index_o  = ils_pkg::FoundIdxW'(fidx_q);
  assign found_o        = found_q;
  assign entry_count_o  = ils_pkg::CountOutW'(count_q);
  assign is_empty_o     = (count_q == '0);

  // A result is only shown once the sequencer is back to idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while a request is still at work");

  // The entry count never passes the capacity.
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count exceeds capacity");

  // The rotation never runs past the occupied cells.
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (scan_q < count_q))
    else $error("rotation past the last entry");

  // Every accepted request either finishes next cycle or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (done_o || busy))
    else $error("accepted request produced neither a result nor work");

endmodule

>>> sv/ils_cell.sv
module ils_cell #(
  parameter int INDEX       = 0,
  parameter int CMP_W       = 9,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  ils_pkg::cell_op_e      op_i,
  input  logic [CMP_W-1:0]       pos_i,
  input  logic [CMP_W-1:0]       cnt_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic [VALUE_WIDTH-1:0] left_i,
  input  logic [VALUE_WIDTH-1:0] right_i,
  input  logic [VALUE_WIDTH-1:0] head_i,
  output logic [VALUE_WIDTH-1:0] data_o
);

  localparam logic [CMP_W-1:0] Idx     = CMP_W'(INDEX);
  localparam logic [CMP_W-1:0] IdxNext = CMP_W'(INDEX + 1);

  logic [VALUE_WIDTH-1:0] data_q;
  logic [VALUE_WIDTH-1:0] data_d;

  // Choose between holding, the new value, the neighbors and the head.
  always_comb begin
    data_d = data_q;
    unique case (op_i)
      ils_pkg::CELL_WRITE: begin
        if (Idx == pos_i) data_d = value_i;
      end
      ils_pkg::CELL_INSERT: begin
        if (Idx == pos_i) begin
          data_d = value_i;
        end else if (Idx > pos_i) begin
          data_d = left_i;
        end
      end
      ils_pkg::CELL_REMOVE: begin
        if (Idx >= pos_i) data_d = right_i;
      end
      ils_pkg::CELL_ROTATE: begin
        // The occupied cells turn by one; the last occupied one takes the head.
        if (IdxNext == cnt_i) begin
          data_d = head_i;
        end else if (IdxNext < cnt_i) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
